// ===== hdl/pmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types and constants of the path MTU cache: operation codes, register
// indexes, controller states and the records passed along the row of cells.
// ----------------------------------------------------------------------------
package pmc_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int IDX_W             = 8;

  localparam logic [15:0] MTU_MIN         = 16'd68;
  localparam logic [15:0] MTU_MAX         = 16'hFFFF;
  localparam logic [31:0] EXPIRY_START    = 32'hFFFF_FFFF;
  localparam logic [15:0] DEFAULT_MTU_RST = 16'd1500;
  localparam logic [31:0] LIFETIME_RST    = 32'd600000;

  typedef enum logic [1:0] {
    FUNC_GET    = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_AGE    = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic {
    CFG_DEFAULT_MTU = 1'b0,
    CFG_LIFETIME    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_AGE,
    CMD_CLEAR
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [IDX_W-1:0] idx;
    logic [31:0]      dest;
    logic [15:0]      mtu;
    logic [31:0]      expiry;
    logic [31:0]      now;
  } cell_cmd_t;

  typedef struct packed {
    logic             v;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic [15:0]      found_mtu;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [31:0]      best_exp;
    logic [IDX_W-1:0] best_idx;
  } scan_rec_t;

endpackage

// ===== hdl/pmc_req_if.sv =====
// ----------------------------------------------------------------------------
// pmc_req_if
// Request channel of the path MTU cache: valid/ready plus operation fields.
// ----------------------------------------------------------------------------
interface pmc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] dest_addr;
  logic [31:0] mtu_value;
  logic [31:0] now_ms;

  modport source (output valid, func, dest_addr, mtu_value, now_ms, input ready);
  modport sink   (input valid, func, dest_addr, mtu_value, now_ms, output ready);
endinterface

// ===== hdl/pmc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pmc_rsp_if
// Response channel of the path MTU cache: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface pmc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] path_mtu;
  logic        hit;

  modport source (output valid, path_mtu, hit, input ready);
  modport sink   (input valid, path_mtu, hit, output ready);
endinterface

// ===== hdl/pmc_cell.sv =====
// ----------------------------------------------------------------------------
// pmc_cell
// One table entry. Folds its entry into the passing scan record and registers it
// before handing it on; applies broadcast write, age and clear commands.
// ----------------------------------------------------------------------------
module pmc_cell #(
  parameter int CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       key_i,
  input  pmc_pkg::cell_cmd_t cmd_i,
  input  pmc_pkg::scan_rec_t rec_i,
  output pmc_pkg::scan_rec_t rec_o
);

  localparam logic [pmc_pkg::IDX_W-1:0] MyIdx = pmc_pkg::IDX_W'(CellIdx);

  logic        valid_q, valid_d;
  logic [31:0] dest_q, dest_d;
  logic [15:0] mtu_q, mtu_d;
  logic [31:0] exp_q, exp_d;
  logic [31:0] age_diff;
  logic        age_due;

  pmc_pkg::scan_rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_i;
    if (!rec_i.found && valid_q && (dest_q == key_i)) begin
      rec_d.found     = 1'b1;
      rec_d.found_idx = MyIdx;
      rec_d.found_mtu = mtu_q;
    end
    if (!rec_i.free_found && !valid_q) begin
      rec_d.free_found = 1'b1;
      rec_d.free_idx   = MyIdx;
    end
    if (exp_q < rec_i.best_exp) begin
      rec_d.best_exp = exp_q;
      rec_d.best_idx = MyIdx;
    end
  end

  assign age_diff = cmd_i.now - exp_q;
  assign age_due  = valid_q && (exp_q != '0) && (age_diff != '0) && !age_diff[31];

  always_comb begin
    valid_d = valid_q;
    dest_d  = dest_q;
    mtu_d   = mtu_q;
    exp_d   = exp_q;
    case (cmd_i.cmd)
      pmc_pkg::CMD_WRITE: begin
        if (cmd_i.idx == MyIdx) begin
          valid_d = 1'b1;
          dest_d  = cmd_i.dest;
          mtu_d   = cmd_i.mtu;
          exp_d   = cmd_i.expiry;
        end
      end
      pmc_pkg::CMD_AGE: begin
        if (age_due) begin
          valid_d = 1'b0;
        end
      end
      pmc_pkg::CMD_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rec_q   <= '0;
    end else begin
      valid_q <= valid_d;
      rec_q   <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q <= dest_d;
    mtu_q  <= mtu_d;
    exp_q  <= exp_d;
  end

  assign rec_o = rec_q;

endmodule

// ===== hdl/path_mtu_cache_top.sv =====
// get/update: a scan record walks the row of cells, one cell per cycle, and the
// result from the last cell is registered before the response is built
// age/clear act on all cells at once, with no scan of the row
// one transaction at a time: the next request is taken only once the last has finished;
// a finished response waits in the output register
// reset empties the table at once and loads the register defaults
// ----------------------------------------------------------------------------
// path_mtu_cache_top
// Associative path MTU table keyed by IPv4 destination, built as a row of
// cells with a small controller for lookup, update, ageing and clearing.
// ----------------------------------------------------------------------------
module path_mtu_cache_top #(
  parameter int TableEntries = pmc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pmc_req_if.sink     req,
  pmc_rsp_if.source   rsp,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  pmc_pkg::state_e    state_q, state_d;
  pmc_pkg::func_e     func_q;
  logic [31:0]        key_q, mtu_in_q, now_q;
  logic [15:0]        default_mtu_q;
  logic [31:0]        lifetime_q;
  pmc_pkg::scan_rec_t res_q;
  logic               rsp_valid_q, rsp_valid_d;
  logic [15:0]        rsp_mtu_q, rsp_mtu_d;
  logic               rsp_hit_q, rsp_hit_d;

  logic               req_fire, out_free, launch, finish;
  logic [15:0]        mtu_clamped, mtu_keep;
  pmc_pkg::scan_rec_t launch_rec;
  pmc_pkg::cell_cmd_t cmd;
  pmc_pkg::scan_rec_t rec_chain [TableEntries+1];

  assign req.ready = (state_q == pmc_pkg::ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp_valid_q || rsp.ready;

  assign mtu_clamped = (mtu_in_q < 32'(pmc_pkg::MTU_MIN)) ? pmc_pkg::MTU_MIN :
                       (mtu_in_q[31:16] != '0)            ? pmc_pkg::MTU_MAX :
                                                            mtu_in_q[15:0];
  assign mtu_keep = ((mtu_clamped < res_q.found_mtu) || (res_q.found_mtu == '0)) ?
                    mtu_clamped : res_q.found_mtu;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pmc_pkg::ST_IDLE: begin
        if (req_fire) state_d = pmc_pkg::ST_LAUNCH;
      end
      pmc_pkg::ST_LAUNCH: begin
        if (func_q == pmc_pkg::FUNC_GET || func_q == pmc_pkg::FUNC_UPDATE) begin
          state_d = pmc_pkg::ST_SCAN;
        end else begin
          state_d = pmc_pkg::ST_FINISH;
        end
      end
      pmc_pkg::ST_SCAN: begin
        if (rec_chain[TableEntries].v) state_d = pmc_pkg::ST_FINISH;
      end
      pmc_pkg::ST_FINISH: begin
        if (out_free) state_d = pmc_pkg::ST_IDLE;
      end
      default: state_d = pmc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    launch = 1'b0;
    finish = 1'b0;
    case (state_q)
      pmc_pkg::ST_LAUNCH: begin
        launch = (func_q == pmc_pkg::FUNC_GET || func_q == pmc_pkg::FUNC_UPDATE);
      end
      pmc_pkg::ST_FINISH: begin
        finish = out_free;
      end
      default: begin
        launch = 1'b0;
      end
    endcase
  end

  always_comb begin
    launch_rec            = '0;
    launch_rec.v          = launch;
    launch_rec.best_exp   = pmc_pkg::EXPIRY_START;

    cmd        = '0;
    cmd.cmd    = pmc_pkg::CMD_NONE;
    cmd.dest   = key_q;
    cmd.now    = now_q;
    cmd.expiry = now_q + lifetime_q;
    cmd.mtu    = res_q.found ? mtu_keep : mtu_clamped;
    cmd.idx    = res_q.found      ? res_q.found_idx :
                 res_q.free_found ? res_q.free_idx  : res_q.best_idx;

    rsp_mtu_d   = rsp_mtu_q;
    rsp_hit_d   = rsp_hit_q;
    rsp_valid_d = rsp_valid_q && !rsp.ready;

    if (finish) begin
      rsp_valid_d = 1'b1;
      rsp_mtu_d   = '0;
      rsp_hit_d   = 1'b0;
      case (func_q)
        pmc_pkg::FUNC_GET: begin
          rsp_mtu_d = res_q.found ? res_q.found_mtu : default_mtu_q;
          rsp_hit_d = res_q.found;
        end
        pmc_pkg::FUNC_UPDATE: begin
          cmd.cmd   = pmc_pkg::CMD_WRITE;
          rsp_hit_d = res_q.found;
        end
        pmc_pkg::FUNC_AGE:   cmd.cmd = pmc_pkg::CMD_AGE;
        pmc_pkg::FUNC_CLEAR: cmd.cmd = pmc_pkg::CMD_CLEAR;
        default:             cmd.cmd = pmc_pkg::CMD_NONE;
      endcase
    end
  end

  assign rec_chain[0] = launch_rec;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    pmc_cell #(
      .CellIdx (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .cmd_i  (cmd),
      .rec_i  (rec_chain[g]),
      .rec_o  (rec_chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pmc_pkg::ST_IDLE;
      rsp_valid_q   <= 1'b0;
      default_mtu_q <= pmc_pkg::DEFAULT_MTU_RST;
      lifetime_q    <= pmc_pkg::LIFETIME_RST;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        case (pmc_pkg::cfg_idx_e'(cfg_idx_i))
          pmc_pkg::CFG_DEFAULT_MTU: default_mtu_q <= cfg_wdata_i[15:0];
          pmc_pkg::CFG_LIFETIME:    lifetime_q    <= cfg_wdata_i;
          default:                  lifetime_q    <= lifetime_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      func_q   <= pmc_pkg::func_e'(req.func);
      key_q    <= req.dest_addr;
      mtu_in_q <= req.mtu_value;
      now_q    <= req.now_ms;
    end
    if (state_q == pmc_pkg::ST_SCAN && rec_chain[TableEntries].v) begin
      res_q <= rec_chain[TableEntries];
    end
    rsp_mtu_q <= rsp_mtu_d;
    rsp_hit_q <= rsp_hit_d;
  end

  assign rsp.valid    = rsp_valid_q;
  assign rsp.path_mtu = rsp_mtu_q;
  assign rsp.hit      = rsp_hit_q;

endmodule

// ===== hdl/pmc_checker.sv =====
// ----------------------------------------------------------------------------
// pmc_checker
// Port-level checks of the path MTU cache, bound to the top level.
// ----------------------------------------------------------------------------
module pmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [15:0] rsp_path_mtu_i,
  input logic        rsp_hit_i
);

  logic [1:0] pending_q, pending_d;
  logic       in_fire, out_fire;

  assign in_fire  = req_valid_i && req_ready_i;
  assign out_fire = rsp_valid_i && rsp_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_fire && !out_fire) pending_d = pending_q + 2'd1;
    if (!in_fire && out_fire) pending_d = pending_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_rsp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_path_mtu_i) && $stable(rsp_hit_i))
    else $error("response payload changed while stalled");

  a_hit_mtu : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_hit_i |->
      (rsp_path_mtu_i == '0) || (rsp_path_mtu_i >= pmc_pkg::MTU_MIN))
    else $error("hit with an mtu below the clamp range");

  a_no_orphan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != '0)
    else $error("response without an outstanding transaction");

endmodule

bind path_mtu_cache_top pmc_checker u_pmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req.valid),
  .req_ready_i    (req.ready),
  .rsp_valid_i    (rsp.valid),
  .rsp_ready_i    (rsp.ready),
  .rsp_path_mtu_i (rsp.path_mtu),
  .rsp_hit_i      (rsp.hit)
);

// ===== test/path_mtu_cache_top_tb.sv =====
// ----------------------------------------------------------------------------
// path_mtu_cache_top_tb
// Self-checking bench for the path MTU cache. It keeps its own copy of the
// table and predicts the response to every accepted request. Traffic is a
// short directed opening, then random lookups, updates, ageing and clears.
// Both channels idle at random, and the register settings change between
// phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module path_mtu_cache_top_tb;
  import pmc_pkg::*;

  localparam int          CLK_PERIOD      = 8;
  localparam int          TABLE_SLOTS     = TABLE_ENTRIES_DEF;
  localparam int          TAIL_CYCLES     = 32;
  localparam int          RSP_HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          KEY_POOL_SIZE   = 24;
  localparam logic [31:0] NEAR_WRAP       = 32'hFFFF_F000;

  typedef struct packed {
    logic [15:0] path_mtu;
    logic        hit;
  } mtu_result_t;

  class mtu_cache_scoreboard;
    logic        slot_used   [TABLE_SLOTS];
    logic [31:0] slot_key    [TABLE_SLOTS];
    logic [15:0] slot_mtu    [TABLE_SLOTS];
    logic [31:0] slot_expiry [TABLE_SLOTS];
    logic [15:0] default_mtu;
    logic [31:0] lifetime_ms;
    mtu_result_t pending_results [$];
    int          errors;

    function new();
      clear_table();
      default_mtu = DEFAULT_MTU_RST;
      lifetime_ms = LIFETIME_RST;
      errors      = 0;
    endfunction

    function void clear_table();
      for (int k = 0; k < TABLE_SLOTS; k++) begin
        slot_used[k]   = 1'b0;
        slot_key[k]    = '0;
        slot_mtu[k]    = '0;
        slot_expiry[k] = '0;
      end
    endfunction

    function int find_key(logic [31:0] key);
      for (int k = 0; k < TABLE_SLOTS; k++) begin
        if (slot_used[k] && slot_key[k] == key) return k;
      end
      return -1;
    endfunction

    function void set_register(cfg_idx_e idx, logic [31:0] value);
      if (idx == CFG_DEFAULT_MTU) default_mtu = value[15:0];
      else lifetime_ms = value;
    endfunction

    function void note_request(func_e op, logic [31:0] key, logic [31:0] mtu_in,
                               logic [31:0] now);
      mtu_result_t res;
      int          k;
      logic [15:0] mtu;
      logic [31:0] best;
      logic [31:0] diff;
      res = '0;
      case (op)
        FUNC_GET: begin
          k = find_key(key);
          if (k >= 0) begin
            res.path_mtu = slot_mtu[k];
            res.hit      = 1'b1;
          end else begin
            res.path_mtu = default_mtu;
          end
        end
        FUNC_UPDATE: begin
          if (mtu_in < {16'd0, MTU_MIN}) mtu = MTU_MIN;
          else if (mtu_in > {16'd0, MTU_MAX}) mtu = MTU_MAX;
          else mtu = mtu_in[15:0];
          k = find_key(key);
          if (k >= 0) begin
            res.hit = 1'b1;
            if (mtu < slot_mtu[k] || slot_mtu[k] == 16'd0) slot_mtu[k] = mtu;
          end else begin
            for (int j = TABLE_SLOTS - 1; j >= 0; j--) begin
              if (!slot_used[j]) k = j;
            end
            if (k < 0) begin
              // every slot busy: evict the earliest expiry, lowest index first
              k    = 0;
              best = EXPIRY_START;
              for (int j = 0; j < TABLE_SLOTS; j++) begin
                if (slot_expiry[j] < best) begin
                  best = slot_expiry[j];
                  k    = j;
                end
              end
            end
            slot_used[k] = 1'b1;
            slot_key[k]  = key;
            slot_mtu[k]  = mtu;
          end
          slot_expiry[k] = now + lifetime_ms;
        end
        FUNC_AGE: begin
          for (int j = 0; j < TABLE_SLOTS; j++) begin
            diff = now - slot_expiry[j];
            if (slot_used[j] && slot_expiry[j] != 32'd0 && diff != 32'd0 && !diff[31])
              slot_used[j] = 1'b0;
          end
        end
        default: clear_table();
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_response(logic [15:0] path_mtu, logic hit);
      mtu_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual path_mtu %0d hit %0b",
                 $time, path_mtu, hit);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (path_mtu !== exp_res.path_mtu) begin
        $display("%0t: path_mtu mismatch, expected %0d, actual %0d",
                 $time, exp_res.path_mtu, path_mtu);
        errors++;
      end
      if (hit !== exp_res.hit) begin
        $display("%0t: hit mismatch, expected %0b, actual %0b", $time, exp_res.hit, hit);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  pmc_req_if req_ch ();
  pmc_rsp_if rsp_ch ();

  mtu_cache_scoreboard sb;
  logic [31:0]         key_pool [KEY_POOL_SIZE];
  logic [31:0]         now_clk;
  int                  burst_left;
  int                  cycle_count = 0;
  bit                  rsp_hold_req = 1'b0;

  path_mtu_cache_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("path_mtu_cache_top_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.path_mtu, rsp_ch.hit);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(func_e'(req_ch.func), req_ch.dest_addr, req_ch.mtu_value,
                        req_ch.now_ms);
    end
  end

  // response side: ready follows one of four stall patterns, redrawn at random
  initial begin : rsp_sink
    int hold_left;
    int mode;
    int mode_left;
    int tick;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      tick++;
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        hold_left    = RSP_HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          2:       rsp_ch.ready <= ($urandom_range(0, 7) != 0);
          default: rsp_ch.ready <= ((tick % 5) < 3);
        endcase
      end
    end
  end

  function automatic logic [31:0] rand_mtu();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 80);
    else if (r < 65) return $urandom_range(500, 9000);
    else if (r < 80) return $urandom_range(60000, 70000);
    else return $urandom;
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
  endfunction

  task automatic send_request(func_e op, logic [31:0] dest, logic [31:0] mtu,
                              logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_ch.valid     <= 1'b1;
    req_ch.func      <= op;
    req_ch.dest_addr <= dest;
    req_ch.mtu_value <= mtu;
    req_ch.now_ms    <= now;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    sb.set_register(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_phase(logic [15:0] dflt, logic [31:0] life);
    wait_idle();
    write_register(CFG_DEFAULT_MTU, {16'd0, dflt});
    write_register(CFG_LIFETIME, life);
  endtask

  task automatic run_random(int count);
    int          done;
    int          kind;
    int          r;
    logic [31:0] t;
    logic [31:0] first_key;
    func_e       op;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        now_clk += $urandom_range(0, 3000);
        r  = $urandom_range(0, 99);
        op = (r < 45) ? FUNC_GET : (r < 85) ? FUNC_UPDATE : (r < 97) ? FUNC_AGE : FUNC_CLEAR;
        send_request(op, pick_key(), rand_mtu(), now_clk);
        done++;
      end else if (kind < 72) begin
        // fill the whole table at one time stamp so that eviction follows
        t         = ($urandom_range(0, 1) == 1) ? 32'd0 : now_clk;
        first_key = $urandom;
        send_request(FUNC_UPDATE, first_key, rand_mtu(), t);
        for (int k = 0; k < TABLE_SLOTS; k++)
          send_request(FUNC_UPDATE, $urandom, rand_mtu(), t);
        send_request(FUNC_GET, first_key, $urandom, t);
        done += TABLE_SLOTS + 2;
      end else if (kind < 87) begin
        // age exactly at the expiry, then one ms later
        first_key = pick_key();
        t         = now_clk + sb.lifetime_ms;
        send_request(FUNC_UPDATE, first_key, rand_mtu(), now_clk);
        send_request(FUNC_AGE, $urandom, $urandom, t);
        send_request(FUNC_GET, first_key, $urandom, t);
        send_request(FUNC_AGE, $urandom, $urandom, t + 32'd1);
        send_request(FUNC_GET, first_key, $urandom, t + 32'd1);
        done += 5;
      end else if (kind < 95) begin
        send_request(func_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        done++;
      end else if (kind < 97) begin
        wait_idle();
      end else begin
        now_clk = ($urandom_range(0, 1) == 1) ? $urandom
                                              : NEAR_WRAP + $urandom_range(0, 4000);
      end
    end
  endtask

  initial begin : stimulus
    sb               = new();
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_DEFAULT_MTU;
    cfg_wdata_i      = '0;
    req_ch.valid     = 1'b0;
    req_ch.func      = FUNC_GET;
    req_ch.dest_addr = '0;
    req_ch.mtu_value = '0;
    req_ch.now_ms    = '0;
    rsp_ch.ready     = 1'b0;
    burst_left       = 0;
    now_clk          = 32'd1000;
    key_pool[0]      = 32'h0000_0000;
    key_pool[1]      = 32'hFFFF_FFFF;
    for (int k = 2; k < KEY_POOL_SIZE; k++) key_pool[k] = $urandom;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values
    send_request(FUNC_GET,    32'h0000_0000, 32'd0,         32'd0);
    send_request(FUNC_UPDATE, 32'h0000_0000, 32'd0,         32'd100);
    send_request(FUNC_GET,    32'h0000_0000, 32'd0,         32'd100);
    send_request(FUNC_UPDATE, 32'h0000_0000, 32'd9000,      32'd100);
    send_request(FUNC_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd200);
    send_request(FUNC_UPDATE, 32'hFFFF_FFFF, 32'd65535,     32'd200);
    send_request(FUNC_UPDATE, 32'hC0A8_0001, 32'd67,        32'd300);
    send_request(FUNC_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd300);
    send_request(FUNC_AGE,    32'h0000_0000, 32'd0,         32'd600150);
    send_request(FUNC_AGE,    32'hFFFF_FFFF, 32'd0,         32'd600200);
    send_request(FUNC_GET,    32'hFFFF_FFFF, 32'd0,         32'd600200);
    send_request(FUNC_AGE,    32'h0000_0000, 32'd0,         32'h8000_0000 + 32'd600300);
    send_request(FUNC_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(FUNC_GET,    32'hC0A8_0001, 32'd0,         32'd0);
    run_random(150);

    // zero lifetime: an expiry of zero never ages out
    set_phase(MTU_MIN, 32'd0);
    send_request(FUNC_UPDATE, 32'h0A00_0001, 32'd1400, 32'd0);
    send_request(FUNC_AGE,    32'h0A00_0001, 32'd0,    32'd5);
    send_request(FUNC_GET,    32'h0A00_0001, 32'd0,    32'd5);
    send_request(FUNC_GET,    32'h0A00_0002, 32'd0,    32'd5);
    run_random(150);

    set_phase(MTU_MAX, 32'hFFFF_FFFF);
    run_random(200);

    // short lifetime, with a long response stall against a busy sender
    set_phase(16'd9000, 32'd1000);
    rsp_hold_req = 1'b1;
    run_random(250);

    set_phase(DEFAULT_MTU_RST, $urandom_range(1000, 2000000));
    run_random(300);

    wait_idle();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("path_mtu_cache_top_tb: PASS");
    end else begin
      $display("path_mtu_cache_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== path_mtu_cache_top.f =====
hdl/pmc_pkg.sv
hdl/pmc_req_if.sv
hdl/pmc_rsp_if.sv
hdl/pmc_cell.sv
hdl/path_mtu_cache_top.sv
hdl/pmc_checker.sv
test/path_mtu_cache_top_tb.sv
